// ----- design/sensor_frame_crc_check_convert_assert.svh -----
// assertion macros for the sensor frame checker
`ifndef SENSOR_FRAME_CRC_CHECK_CONVERT_ASSERT_SVH
`define SENSOR_FRAME_CRC_CHECK_CONVERT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked from the end of reset
`define SFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sfc assertion failed");
// next-cycle implication, checked from the end of reset
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sfc assertion failed");
`else
`define SFC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/sfc_pkg.sv -----
// shared types, constants and the crc step for the sensor frame checker
`default_nettype none
package sfc_pkg;

	localparam logic [7:0]  CRC_POLY    = 8'h31;
	localparam logic [15:0] STATUS_MASK = 16'hFFFC;
	localparam logic [14:0] TEMP_GAIN   = 15'd17572;
	localparam logic [14:0] TEMP_OFFSET = 15'd4685;
	localparam logic [14:0] HUM_GAIN    = 15'd12500;
	localparam logic [14:0] HUM_OFFSET  = 15'd600;
	localparam logic        KIND_TEMP   = 1'b0;

	// position of the next word within a frame
	typedef enum logic [1:0] {
		POS_MSB,
		POS_LSB,
		POS_CRC
	} sfc_pos_t;

	// checked frame waiting for conversion
	typedef struct packed {
		logic        crc_ok;
		logic [15:0] raw;
		logic        kind;
	} sfc_item_t;

	// frame tracker status seen by the top level checks
	typedef struct packed {
		sfc_pos_t pos;
		logic     valid;
	} sfc_frame_stat_t;

	// crc-8, msb first, one full byte folded in
	function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- design/sfc_frame.sv -----
// frame tracker: byte position, running crc, and the checked-frame register
`default_nettype none
module sfc_frame (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [7:0]              rx_byte,
	input  wire logic                    frame_start,
	input  wire logic                    kind,
	input  wire logic                    byte_valid,
	output logic                         byte_stall,
	input  wire logic                    next_ready,
	output sfc_pkg::sfc_item_t           item_s1,
	output logic                         valid_s1,
	output sfc_pkg::sfc_frame_stat_t     stat
);

	sfc_pkg::sfc_pos_t pos_q;
	sfc_pkg::sfc_pos_t pos_eff;
	sfc_pkg::sfc_pos_t pos_next;
	logic [7:0]        crc_q;
	logic [7:0]        crc_base;
	logic [7:0]        crc_new;
	logic [7:0]        high_q;
	logic [7:0]        low_q;
	logic              accept;
	logic              ready;
	logic              last_word;

	// handshake: room when the frame register is empty or moves on
	assign ready      = !valid_s1 || next_ready;
	assign byte_stall = !ready;
	assign accept     = byte_valid && ready;

	// effective position, a start mark forces the msb slot
	always_comb begin
		pos_eff = frame_start ? sfc_pkg::POS_MSB : pos_q;
	end

	// next position
	always_comb begin
		unique case (pos_eff)
			sfc_pkg::POS_LSB: pos_next = sfc_pkg::POS_CRC;
			sfc_pkg::POS_CRC: pos_next = sfc_pkg::POS_MSB;
			default:          pos_next = sfc_pkg::POS_LSB;
		endcase
	end

	// crc fold and checksum detection
	always_comb begin
		last_word = (pos_eff == sfc_pkg::POS_CRC);
		crc_base  = (pos_eff == sfc_pkg::POS_LSB) ? crc_q : 8'h00;
		crc_new   = sfc_pkg::crc8_fold(crc_base, rx_byte);
	end

	// position and crc state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= sfc_pkg::POS_MSB;
			crc_q  <= 8'h00;
			high_q <= 8'h00;
			low_q  <= 8'h00;
		end else if (accept) begin
			pos_q <= pos_next;
			if (last_word) begin
				crc_q <= 8'h00;
			end else begin
				crc_q <= crc_new;
			end
			if (pos_eff == sfc_pkg::POS_LSB) begin
				low_q <= rx_byte;
			end else if (!last_word) begin
				high_q <= rx_byte;
			end
		end
	end

	// checked frame register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && last_word) begin
			valid_s1 <= 1'b1;
		end else if (next_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_word) begin
			item_s1.crc_ok <= (crc_q == rx_byte);
			item_s1.raw    <= {high_q, low_q} & sfc_pkg::STATUS_MASK;
			item_s1.kind   <= kind;
		end
	end

	assign stat.pos   = pos_q;
	assign stat.valid = valid_s1;

endmodule
`default_nettype wire

// ----- design/sfc_scale.sv -----
// scaler: gain multiply, then offset and truncation into the result register
`default_nettype none
module sfc_scale (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sfc_pkg::sfc_item_t  item_s1,
	input  wire logic                valid_s1,
	output logic                     s2_ready,
	output logic                     valid_s2,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic                     crc_ok,
	output logic [15:0]              raw_count,
	output logic signed [14:0]       scaled_value,
	output logic                     kind_out
);

	logic [14:0]        gain;
	logic [30:0]        prod_s2;
	sfc_pkg::sfc_item_t item_s2;
	logic               out_ready;
	logic [14:0]        offset;
	logic [14:0]        whole;
	logic               frac;
	logic signed [15:0] diff;
	logic signed [15:0] trunc;
	logic               result_valid_q;
	logic               crc_ok_q;
	logic [15:0]        raw_q;
	logic [14:0]        scaled_q;
	logic               kind_q;

	// stage handshakes
	assign out_ready = !result_valid_q || !result_stall;
	assign s2_ready  = !valid_s2 || out_ready;

	// gain by kind
	always_comb begin
		gain = (item_s1.kind == sfc_pkg::KIND_TEMP) ? sfc_pkg::TEMP_GAIN : sfc_pkg::HUM_GAIN;
	end

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			prod_s2 <= 31'(item_s1.raw) * 31'(gain);
			item_s2 <= item_s1;
		end
	end

	// drop the 1/65536 scale, subtract offset, truncate toward zero
	always_comb begin
		offset = (item_s2.kind == sfc_pkg::KIND_TEMP) ? sfc_pkg::TEMP_OFFSET
		                                              : sfc_pkg::HUM_OFFSET;
		whole  = prod_s2[30:16];
		frac   = |prod_s2[15:0];
		diff   = $signed({1'b0, whole}) - $signed({1'b0, offset});
		trunc  = (diff < 0 && frac) ? diff + 16'sd1 : diff;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_ready) begin
			result_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			crc_ok_q <= item_s2.crc_ok;
			raw_q    <= item_s2.raw;
			scaled_q <= trunc[14:0];
			kind_q   <= item_s2.kind;
		end
	end

	assign result_valid = result_valid_q;
	assign crc_ok       = crc_ok_q;
	assign raw_count    = raw_q;
	assign scaled_value = $signed(scaled_q);
	assign kind_out     = kind_q;

endmodule
`default_nettype wire

// ----- design/sensor_frame_crc_check_convert.sv -----
// top level of the sensor frame crc checker and converter
`default_nettype none
`include "sensor_frame_crc_check_convert_assert.svh"
// Takes a sensor measurement frame as three words (msb, lsb, crc-8 checksum,
// poly 0x31, init 0) and on the checksum word gives one result: crc_ok, the
// count with its two status bits cleared, the value in hundredths of a degree C
// or of a percent RH (truncated toward zero) and the kind given with the
// checksum word. frame_start marks an msb word and resynchronises; unmarked
// frames may follow back to back. One word is taken every clock cycle while
// byte_stall is low; after its checksum word is taken, a result passes the
// frame register, the multiply stage and the result register, and the stall
// of the result side reaches the input only once all three stages hold data.
module sensor_frame_crc_check_convert (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               frame_start,
	input  wire logic               kind,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic                    crc_ok,
	output logic [15:0]             raw_count,
	output logic signed [14:0]      scaled_value,
	output logic                    kind_out
);

	sfc_pkg::sfc_item_t       item_s1;
	logic                     valid_s1;
	logic                     s2_ready;
	logic                     valid_s2;
	sfc_pkg::sfc_frame_stat_t stat;

	// frame tracking and crc check
	sfc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.kind        (kind),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.next_ready  (s2_ready),
		.item_s1     (item_s1),
		.valid_s1    (valid_s1),
		.stat        (stat)
	);

	// conversion into fixed point
	sfc_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_s1      (item_s1),
		.valid_s1     (valid_s1),
		.s2_ready     (s2_ready),
		.valid_s2     (valid_s2),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.crc_ok       (crc_ok),
		.raw_count    (raw_count),
		.scaled_value (scaled_value),
		.kind_out     (kind_out)
	);

	// a start-marked word always leaves the tracker waiting for the lsb
	`SFC_ASSERT_NEXT(a_start_pos, clk, arst_n, byte_valid && !byte_stall && frame_start, stat.pos == sfc_pkg::POS_LSB)
	// a taken checksum word always fills the frame register
	`SFC_ASSERT_NEXT(a_crc_fills, clk, arst_n, byte_valid && !byte_stall && !frame_start && stat.pos == sfc_pkg::POS_CRC, stat.valid)
	// a full pipe behind a stalled result never loses the product stage
	`SFC_ASSERT_NEXT(a_s2_held, clk, arst_n, valid_s2 && result_valid && result_stall, valid_s2)
	// the input only stalls when every stage is occupied
	`SFC_ASSERT_SAME(a_stall_full, clk, arst_n, byte_stall, valid_s1 && valid_s2 && result_valid)

endmodule
`default_nettype wire
